### src/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg: shared types and constants of the 2x2 box downsampler.
// Pixel, result and pair-sum layouts, position flags and register indexes.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int CHAN_W     = 8;
    localparam int PAIR_W     = CHAN_W + 1;
    localparam int STORE_W    = 10;
    localparam int SUM_W      = STORE_W + 1;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 4;
    localparam int ROW_W      = CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = CFG_IDX_W'(1);

    localparam logic [CFG_DATA_W-1:0] SRC_WIDTH_RESET  = CFG_DATA_W'(1024);
    localparam logic [CFG_DATA_W-1:0] SRC_HEIGHT_RESET = CFG_DATA_W'(1024);

    typedef struct packed {
        logic [CHAN_W-1:0] red_in;
        logic [CHAN_W-1:0] green_in;
        logic [CHAN_W-1:0] blue_in;
    } t_pixel;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              end_of_row;
        logic              end_of_frame;
    } t_result;

    typedef struct packed {
        logic [STORE_W-1:0] red;
        logic [STORE_W-1:0] green;
        logic [STORE_W-1:0] blue;
    } t_pair_sums;

    localparam int PAIRS_W = $bits(t_pair_sums);

    typedef struct packed {
        logic odd_col;
        logic odd_row;
        logic end_of_row;
        logic end_of_frame;
    } t_pos_flags;

endpackage

### src/bds_stream_if.sv
// ----------------------------------------------------------------------------
// bds_stream_if: valid/ready channels of the box downsampler.
// One interface for source pixels and one for output pixels.
// ----------------------------------------------------------------------------
interface bds_pix_if;
    logic            valid;
    logic            ready;
    bds_pkg::t_pixel data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bds_res_if;
    logic             valid;
    logic             ready;
    bds_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/bds_ram.sv
// ----------------------------------------------------------------------------
// bds_ram: generic simple dual-port RAM.
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bds_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/bds_pos.sv
// ----------------------------------------------------------------------------
// bds_pos: frame size registers and source position counters.
// Gives the line store index and the position flags of the next pixel.
// ----------------------------------------------------------------------------
module bds_pos #(
    parameter int MAX_WIDTH = 4096,
    parameter int IDX_W = 11
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bds_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_adv,
    output bds_pkg::t_pos_flags                o_flags,
    output logic [IDX_W-1:0]                   o_idx
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W  = (WEFF_W > bds_pkg::CFG_DATA_W) ? WEFF_W : bds_pkg::CFG_DATA_W;
    localparam int ROW_W  = bds_pkg::ROW_W;

    logic [bds_pkg::CFG_DATA_W-1:0] r_src_width;
    logic [bds_pkg::CFG_DATA_W-1:0] r_src_height;
    logic [COL_W-1:0]               r_col;
    logic [COL_W-1:0]               n_col;
    logic [ROW_W-1:0]               r_row;
    logic [ROW_W-1:0]               n_row;

    logic [CMP_W-1:0] w_nz;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] w_even;
    logic [CMP_W-1:0] x_inc;
    logic             col_wrap;
    logic [ROW_W-1:0] h_eff;
    logic [ROW_W:0]   h_even;
    logic [ROW_W:0]   y_inc;
    logic             eor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bds_pkg::SRC_WIDTH_RESET;
            r_src_height <= bds_pkg::SRC_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bds_pkg::CFG_SRC_WIDTH: begin
                    r_src_width <= i_cfg_data;
                end
                bds_pkg::CFG_SRC_HEIGHT: begin
                    r_src_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_nz     = (r_src_width == '0) ? CMP_W'(1) : CMP_W'(r_src_width);
        w_eff    = (w_nz > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_nz;
        w_even   = w_eff & ~CMP_W'(1);
        x_inc    = CMP_W'(r_col) + CMP_W'(1);
        col_wrap = (x_inc >= w_eff);
        eor      = (x_inc == w_even);

        h_eff  = (r_src_height == '0) ? ROW_W'(1) : r_src_height;
        h_even = {1'b0, h_eff & ~ROW_W'(1)};
        y_inc  = {1'b0, r_row} + (ROW_W + 1)'(1);

        n_col = col_wrap ? '0 : COL_W'(x_inc);
        if (!col_wrap) begin
            n_row = r_row;
        end else if (y_inc >= {1'b0, h_eff}) begin
            n_row = '0;
        end else begin
            n_row = y_inc[ROW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_adv) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_flags.odd_col      = r_col[0];
    assign o_flags.odd_row      = r_row[0];
    assign o_flags.end_of_row   = eor;
    assign o_flags.end_of_frame = eor && (y_inc == h_even);
    assign o_idx                = IDX_W'(r_col >> 1);

endmodule

### src/bds_pipe.sv
// ----------------------------------------------------------------------------
// bds_pipe: pair sum, line store and block average pipeline.
// Input register, pair-sum stage with line store access, result register.
// ----------------------------------------------------------------------------
module bds_pipe #(
    parameter int LINE_DEPTH = 2048,
    parameter int IDX_W = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    bds_pix_if.sink             i_src,
    bds_res_if.source           o_dst,
    input  bds_pkg::t_pos_flags i_flags,
    input  logic [IDX_W-1:0]    i_idx
);

    localparam int STORE_W = bds_pkg::STORE_W;
    localparam int SUM_W   = bds_pkg::SUM_W;

    logic                r_a_valid;
    bds_pkg::t_pixel     r_a_pix;
    bds_pkg::t_pos_flags r_a_flags;
    logic [IDX_W-1:0]    r_a_idx;
    bds_pkg::t_pixel     r_held;
    logic                r_b_valid;
    bds_pkg::t_pair_sums r_b_pair;
    logic                r_b_eor;
    logic                r_b_eof;
    logic                r_out_valid;
    bds_pkg::t_result    r_out;

    bds_pkg::t_pair_sums pair;
    bds_pkg::t_pair_sums above;
    logic [bds_pkg::PAIRS_W-1:0] ram_q;
    logic                a_prod;
    logic                a_move;
    logic                b_move;
    logic                b_free;
    logic                out_free;
    logic                ram_we;
    logic                ram_re;
    logic [SUM_W-1:0]    sum_r;
    logic [SUM_W-1:0]    sum_g;
    logic [SUM_W-1:0]    sum_b;

    always_comb begin
        pair.red   = STORE_W'(r_held.red_in) + STORE_W'(r_a_pix.red_in);
        pair.green = STORE_W'(r_held.green_in) + STORE_W'(r_a_pix.green_in);
        pair.blue  = STORE_W'(r_held.blue_in) + STORE_W'(r_a_pix.blue_in);

        a_prod   = r_a_flags.odd_col && r_a_flags.odd_row;
        out_free = !r_out_valid || o_dst.ready;
        b_move   = r_b_valid && out_free;
        b_free   = !r_b_valid || b_move;
        a_move   = r_a_valid && (!a_prod || b_free);
        ram_we   = a_move && r_a_flags.odd_col && !r_a_flags.odd_row;
        ram_re   = a_move && a_prod;

        above = ram_q;
        sum_r = SUM_W'(above.red) + SUM_W'(r_b_pair.red);
        sum_g = SUM_W'(above.green) + SUM_W'(r_b_pair.green);
        sum_b = SUM_W'(above.blue) + SUM_W'(r_b_pair.blue);
    end

    assign i_src.ready = !r_a_valid || a_move;

    bds_ram #(
        .WIDTH (bds_pkg::PAIRS_W),
        .DEPTH (LINE_DEPTH),
        .ADDR_W(IDX_W)
    ) u_line (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_a_idx),
        .i_wdata(pair),
        .i_re   (ram_re),
        .i_raddr(r_a_idx),
        .o_rdata(ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_src.valid && i_src.ready) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
        if (i_src.valid && i_src.ready) begin
            r_a_pix   <= i_src.data;
            r_a_flags <= i_flags;
            r_a_idx   <= i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (a_move && !r_a_flags.odd_col) begin
            r_held <= r_a_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ram_re) begin
            r_b_valid <= 1'b1;
        end else if (b_move) begin
            r_b_valid <= 1'b0;
        end
        if (ram_re) begin
            r_b_pair <= pair;
            r_b_eor  <= r_a_flags.end_of_row;
            r_b_eof  <= r_a_flags.end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_move) begin
            r_out_valid <= 1'b1;
        end else if (o_dst.ready) begin
            r_out_valid <= 1'b0;
        end
        if (b_move) begin
            r_out.red_out      <= bds_pkg::CHAN_W'(sum_r >> 2);
            r_out.green_out    <= bds_pkg::CHAN_W'(sum_g >> 2);
            r_out.blue_out     <= bds_pkg::CHAN_W'(sum_b >> 2);
            r_out.end_of_row   <= r_b_eor;
            r_out.end_of_frame <= r_b_eof;
        end
    end

    assign o_dst.valid = r_out_valid;
    assign o_dst.data  = r_out;

endmodule

### src/box_downsample_2x2_rgb_top.sv
// ----------------------------------------------------------------------------
// box_downsample_2x2_rgb_top: 2x2 box-filter downsampler for RGB pixels.
// A source transfer reaches a valid output pixel via the input, pair-sum and
// result registers. Throughput is one source pixel per cycle unless output
// stalls, set by the single-pass pipeline, at most one RAM access per pixel.
// Synchronous reset clears counters and pipeline valids and loads both frame
// sizes with 1024; the line store is not cleared.
// ----------------------------------------------------------------------------
module box_downsample_2x2_rgb_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bds_pix_if.sink                        i_src,
    bds_res_if.source                      o_dst
);

    localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    bds_pkg::t_pos_flags pos_flags;
    logic [IDX_W-1:0]    pos_idx;
    logic                src_xfer;

    assign src_xfer = i_src.valid && i_src.ready;

    bds_pos #(
        .MAX_WIDTH(MAX_WIDTH),
        .IDX_W    (IDX_W)
    ) u_pos (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_adv     (src_xfer),
        .o_flags   (pos_flags),
        .o_idx     (pos_idx)
    );

    bds_pipe #(
        .LINE_DEPTH(LINE_DEPTH),
        .IDX_W     (IDX_W)
    ) u_pipe (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_src  (i_src),
        .o_dst  (o_dst),
        .i_flags(pos_flags),
        .i_idx  (pos_idx)
    );

endmodule
